// ===== hw/rtl/tasp_pkg.sv =====
// ----------------------------------------------------------------------------
// tasp_pkg
// Types and constants shared by the step pulse interpolator modules.
// ----------------------------------------------------------------------------
package tasp_pkg;

    localparam int AXES     = 3;
    localparam int POS_BITS = 32;

    localparam logic REQ_MOVE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic latch;
        logic start;
        logic tick;
    } t_axis_ctrl;

endpackage

// ===== hw/rtl/tasp_axis.sv =====
// ----------------------------------------------------------------------------
// tasp_axis
// One axis: direction, magnitude, error accumulator and absolute position.
// ----------------------------------------------------------------------------
module tasp_axis #(
    parameter int STEP_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tasp_pkg::t_axis_ctrl          i_ctrl,
    input  logic [STEP_BITS-1:0]          i_delta,
    input  logic [STEP_BITS-1:0]          i_total,
    output logic [STEP_BITS-2:0]          o_load_mag,
    output logic                          o_step,
    output logic                          o_n_dir,
    output logic [tasp_pkg::POS_BITS-1:0] o_n_pos
);

    logic [STEP_BITS-2:0]          r_mag;
    logic [STEP_BITS-1:0]          r_err;
    logic                          r_dir;
    logic [tasp_pkg::POS_BITS-1:0] r_pos;

    logic [STEP_BITS-2:0]          n_mag;
    logic [STEP_BITS-1:0]          n_err;
    logic [tasp_pkg::POS_BITS-1:0] n_pos;
    logic                          n_dir;

    logic [STEP_BITS-1:0]          w_neg;
    logic                          w_load_dir;
    logic [STEP_BITS-1:0]          w_sum;
    logic                          w_hit;
    logic [tasp_pkg::POS_BITS-1:0] w_mag_ext;

    // The most negative delta saturates to the largest magnitude.
    always_comb begin
        w_load_dir = ~i_delta[STEP_BITS-1];
        w_neg      = ~i_delta + {{(STEP_BITS-1){1'b0}}, 1'b1};
        if (w_load_dir) begin
            o_load_mag = i_delta[STEP_BITS-2:0];
        end else if (w_neg[STEP_BITS-1]) begin
            o_load_mag = {(STEP_BITS-1){1'b1}};
        end else begin
            o_load_mag = w_neg[STEP_BITS-2:0];
        end
    end

    assign w_sum     = r_err + {1'b0, r_mag};
    assign w_hit     = (w_sum >= i_total);
    assign o_step    = i_ctrl.tick & w_hit;
    assign w_mag_ext = {{(tasp_pkg::POS_BITS-STEP_BITS+1){1'b0}}, o_load_mag};

    always_comb begin
        n_mag = r_mag;
        n_dir = r_dir;
        n_err = r_err;
        n_pos = r_pos;
        if (i_ctrl.latch) begin
            n_mag = o_load_mag;
            n_dir = w_load_dir;
        end
        if (i_ctrl.start) begin
            n_err = '0;
            n_pos = w_load_dir ? (r_pos + w_mag_ext) : (r_pos - w_mag_ext);
        end
        if (i_ctrl.tick) begin
            n_err = w_hit ? (w_sum - i_total) : w_sum;
        end
    end

    assign o_n_dir = n_dir;
    assign o_n_pos = n_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag <= '0;
            r_err <= '0;
            r_dir <= 1'b1;
            r_pos <= '0;
        end else begin
            r_mag <= n_mag;
            r_err <= n_err;
            r_dir <= n_dir;
            r_pos <= n_pos;
        end
    end

endmodule

// ===== hw/rtl/three_axis_step_pulse_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// three_axis_step_pulse_interpolator_top
// Three-axis step generator with one error accumulator per axis.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one beat per item. A move beat (req_type
// zero) loads signed step deltas when no move is active and is reported as
// ignored otherwise. A tick beat advances the active move by one tick and
// reports the step pulses of each axis. Every input beat gives exactly one
// output beat carrying steps, directions, busy, finished, ignored and the
// absolute positions after that item.
// A beat is taken into an input register, and from there it is worked in
// one pass of per-axis add and compare logic into the output register.
// One beat is accepted per cycle while the output side does not stall.
// The rate is set by the combinational accumulator update of each axis.
// When the receiver stalls, the output register holds its beat; the input
// register still takes one more beat, then the input side stalls too.
// Reset is synchronous: no move is active, positions and accumulators are
// zero and all directions are positive.
// ----------------------------------------------------------------------------
module three_axis_step_pulse_interpolator_top #(
    parameter int STEP_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  logic signed [STEP_BITS-1:0]   i_delta_x,
    input  logic signed [STEP_BITS-1:0]   i_delta_y,
    input  logic signed [STEP_BITS-1:0]   i_delta_z,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_step_x,
    output logic                          o_step_y,
    output logic                          o_step_z,
    output logic                          o_dir_x,
    output logic                          o_dir_y,
    output logic                          o_dir_z,
    output logic                          o_busy_res,
    output logic                          o_move_finished,
    output logic                          o_load_ignored,
    output logic signed [tasp_pkg::POS_BITS-1:0] o_pos_x,
    output logic signed [tasp_pkg::POS_BITS-1:0] o_pos_y,
    output logic signed [tasp_pkg::POS_BITS-1:0] o_pos_z
);

    localparam int AXES = tasp_pkg::AXES;
    localparam int PB   = tasp_pkg::POS_BITS;

    logic                 r_in_valid;
    logic                 r_req_type;
    logic [STEP_BITS-1:0] r_delta [AXES];

    logic                 r_active;
    logic [STEP_BITS-1:0] r_tick_count;
    logic [STEP_BITS-1:0] r_total;

    logic                 r_out_valid;
    logic [AXES-1:0]      r_step;
    logic [AXES-1:0]      r_dir;
    logic                 r_busy;
    logic                 r_finished;
    logic                 r_ignored;
    logic [PB-1:0]        r_pos [AXES];

    logic                 n_active;
    logic [STEP_BITS-1:0] n_tick_count;
    logic [STEP_BITS-1:0] n_total;

    logic                 w_adv;
    logic                 w_take;
    logic                 w_is_move;
    logic                 w_ignored;
    logic                 w_finish;
    logic [STEP_BITS-1:0] w_tick_inc;
    logic [STEP_BITS-2:0] w_max_xy;
    logic [STEP_BITS-2:0] w_max;
    tasp_pkg::t_axis_ctrl w_ctrl;

    logic [STEP_BITS-2:0] w_load_mag [AXES];
    logic [AXES-1:0]      w_step;
    logic [AXES-1:0]      w_n_dir;
    logic [PB-1:0]        w_n_pos [AXES];

    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_take     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req_type <= i_req_type;
            r_delta[0] <= i_delta_x;
            r_delta[1] <= i_delta_y;
            r_delta[2] <= i_delta_z;
        end
    end

    assign w_max_xy = (w_load_mag[1] > w_load_mag[0]) ? w_load_mag[1] : w_load_mag[0];
    assign w_max    = (w_load_mag[2] > w_max_xy) ? w_load_mag[2] : w_max_xy;

    always_comb begin
        w_is_move    = (r_req_type == tasp_pkg::REQ_MOVE);
        w_ctrl.latch = w_adv && w_is_move && !r_active;
        w_ctrl.start = w_ctrl.latch && (w_max != '0);
        w_ctrl.tick  = w_adv && !w_is_move && r_active;
        w_ignored    = w_adv && w_is_move && r_active;
        w_tick_inc   = r_tick_count + {{(STEP_BITS-1){1'b0}}, 1'b1};
        w_finish     = w_ctrl.tick && (w_tick_inc >= r_total);
        n_active     = r_active;
        n_tick_count = r_tick_count;
        n_total      = r_total;
        if (w_ctrl.latch) begin
            n_total = {1'b0, w_max};
        end
        if (w_ctrl.start) begin
            n_active     = 1'b1;
            n_tick_count = '0;
        end
        if (w_ctrl.tick) begin
            n_tick_count = w_tick_inc;
            if (w_finish) begin
                n_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_tick_count <= '0;
            r_total      <= '0;
        end else begin
            r_active     <= n_active;
            r_tick_count <= n_tick_count;
            r_total      <= n_total;
        end
    end

    for (genvar g = 0; g < AXES; g++) begin : g_axis
        tasp_axis #(
            .STEP_BITS(STEP_BITS)
        ) u_axis (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_delta    (r_delta[g]),
            .i_total    (r_total),
            .o_load_mag (w_load_mag[g]),
            .o_step     (w_step[g]),
            .o_n_dir    (w_n_dir[g]),
            .o_n_pos    (w_n_pos[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_step     <= w_step;
            r_dir      <= w_n_dir;
            r_busy     <= n_active;
            r_finished <= w_finish;
            r_ignored  <= w_ignored;
            r_pos      <= w_n_pos;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_step_x        = r_step[0];
    assign o_step_y        = r_step[1];
    assign o_step_z        = r_step[2];
    assign o_dir_x         = r_dir[0];
    assign o_dir_y         = r_dir[1];
    assign o_dir_z         = r_dir[2];
    assign o_busy_res      = r_busy;
    assign o_move_finished = r_finished;
    assign o_load_ignored  = r_ignored;
    assign o_pos_x         = r_pos[0];
    assign o_pos_y         = r_pos[1];
    assign o_pos_z         = r_pos[2];

    a_finish_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_move_finished) |-> !o_busy_res)
        else $error("Finished move still reported busy.");

    a_ignored_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_load_ignored) |->
            (!o_step_x && !o_step_y && !o_step_z && !o_move_finished && o_busy_res))
        else $error("Ignored move beat carries tick results.");

    a_active_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_total != '0))
        else $error("Move active with zero total ticks.");

    a_tick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_tick_count < r_total))
        else $error("Tick count ran past the move total.");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the three-axis step pulse interpolator against a cycle-free
// predictor of its move and tick behavior. A queue of move and tick beats is
// fed with random gaps while the output side stalls at random, and every
// output beat is compared field by field with the predicted report.
// ----------------------------------------------------------------------------
module testbench;

    localparam int STEP_BITS   = 24;
    localparam int STALL_LIMIT = 2000;
    localparam int N_RANDOM    = 1240;
    localparam logic [STEP_BITS-1:0] MAG_LIMIT = {1'b0, {(STEP_BITS-1){1'b1}}};

    typedef struct {
        logic                 kind;
        logic [STEP_BITS-1:0] dx;
        logic [STEP_BITS-1:0] dy;
        logic [STEP_BITS-1:0] dz;
    } t_motion_cmd;

    typedef struct packed {
        logic [tasp_pkg::AXES-1:0]                         step;
        logic [tasp_pkg::AXES-1:0]                         dir;
        logic                                              busy;
        logic                                              finished;
        logic                                              ignored;
        logic [tasp_pkg::AXES-1:0][tasp_pkg::POS_BITS-1:0] pos;
    } t_step_report;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_in_valid = 1'b0;
    logic                                 o_in_stall;
    logic                                 i_req_type = tasp_pkg::REQ_TICK;
    logic signed [STEP_BITS-1:0]          i_delta_x = '0;
    logic signed [STEP_BITS-1:0]          i_delta_y = '0;
    logic signed [STEP_BITS-1:0]          i_delta_z = '0;
    logic                                 o_out_valid;
    logic                                 i_out_stall = 1'b0;
    logic                                 o_step_x;
    logic                                 o_step_y;
    logic                                 o_step_z;
    logic                                 o_dir_x;
    logic                                 o_dir_y;
    logic                                 o_dir_z;
    logic                                 o_busy_res;
    logic                                 o_move_finished;
    logic                                 o_load_ignored;
    logic signed [tasp_pkg::POS_BITS-1:0] o_pos_x;
    logic signed [tasp_pkg::POS_BITS-1:0] o_pos_y;
    logic signed [tasp_pkg::POS_BITS-1:0] o_pos_z;

    t_motion_cmd  cmd_queue [$];
    t_step_report expected_reports [$];
    t_motion_cmd  cmd;
    t_step_report want;

    logic                          moving = 1'b0;
    logic [STEP_BITS-1:0]          ticks_done = '0;
    logic [STEP_BITS-1:0]          ticks_total = '0;
    logic [STEP_BITS-2:0]          mag_q [tasp_pkg::AXES] = '{default: '0};
    logic [STEP_BITS-1:0]          acc_q [tasp_pkg::AXES] = '{default: '0};
    logic                          dir_q [tasp_pkg::AXES] = '{default: 1'b1};
    logic [tasp_pkg::POS_BITS-1:0] pos_q [tasp_pkg::AXES] = '{default: '0};

    logic beat_taken = 1'b0;
    int   beats_in = 0;
    int   n_items = 0;
    int   mismatches = 0;
    int   quiet_cycles = 0;
    int   gap_in = 0;
    int   calm_in = 0;
    int   stall_left = 0;
    int   calm_out = 0;

    three_axis_step_pulse_interpolator_top #(
        .STEP_BITS(STEP_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_delta_x      (i_delta_x),
        .i_delta_y      (i_delta_y),
        .i_delta_z      (i_delta_z),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_step_x       (o_step_x),
        .o_step_y       (o_step_y),
        .o_step_z       (o_step_z),
        .o_dir_x        (o_dir_x),
        .o_dir_y        (o_dir_y),
        .o_dir_z        (o_dir_z),
        .o_busy_res     (o_busy_res),
        .o_move_finished(o_move_finished),
        .o_load_ignored (o_load_ignored),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_pos_z        (o_pos_z)
    );

    always #5 i_clk = ~i_clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    function automatic int span_of(logic [STEP_BITS-1:0] d);
        logic [STEP_BITS-1:0] m;
        m = d[STEP_BITS-1] ? -d : d;
        if (m > MAG_LIMIT) begin
            m = MAG_LIMIT;
        end
        return int'(m);
    endfunction

    function automatic logic [STEP_BITS-1:0] short_delta();
        int r;
        int m;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            m = 0;
        end else if (r < 85) begin
            m = $urandom_range(1, 12);
        end else if (r < 97) begin
            m = $urandom_range(13, 60);
        end else begin
            m = $urandom_range(61, 300);
        end
        return $urandom_range(0, 1) ? STEP_BITS'(m) : STEP_BITS'(-m);
    endfunction

    task automatic push_move(input logic [STEP_BITS-1:0] dx, dy, dz);
        cmd_queue.push_back('{tasp_pkg::REQ_MOVE, dx, dy, dz});
    endtask

    task automatic push_tick();
        cmd_queue.push_back('{tasp_pkg::REQ_TICK, STEP_BITS'($urandom),
                              STEP_BITS'($urandom), STEP_BITS'($urandom)});
    endtask

    task automatic push_noise_move();
        push_move(STEP_BITS'($urandom), STEP_BITS'($urandom), STEP_BITS'($urandom));
    endtask

    task automatic advance_interpolator(input logic kind,
                                        input logic [STEP_BITS-1:0] dx, dy, dz);
        logic [STEP_BITS-1:0]          d [tasp_pkg::AXES];
        logic [STEP_BITS-1:0]          m;
        logic [STEP_BITS:0]            sum;
        logic [STEP_BITS-2:0]          widest;
        logic [tasp_pkg::POS_BITS-1:0] mag_ext;
        t_step_report                  r;
        d[0] = dx;
        d[1] = dy;
        d[2] = dz;
        r = '0;
        if (kind == tasp_pkg::REQ_MOVE) begin
            if (moving) begin
                r.ignored = 1'b1;
            end else begin
                widest = '0;
                for (int a = 0; a < tasp_pkg::AXES; a++) begin
                    m = d[a][STEP_BITS-1] ? -d[a] : d[a];
                    if (m > MAG_LIMIT) begin
                        m = MAG_LIMIT;
                    end
                    dir_q[a] = !d[a][STEP_BITS-1];
                    mag_q[a] = m[STEP_BITS-2:0];
                    if (mag_q[a] > widest) begin
                        widest = mag_q[a];
                    end
                end
                ticks_total = {1'b0, widest};
                if (widest != '0) begin
                    moving = 1'b1;
                    ticks_done = '0;
                    for (int a = 0; a < tasp_pkg::AXES; a++) begin
                        acc_q[a] = '0;
                        mag_ext = {{(tasp_pkg::POS_BITS-STEP_BITS+1){1'b0}}, mag_q[a]};
                        pos_q[a] = dir_q[a] ? pos_q[a] + mag_ext : pos_q[a] - mag_ext;
                    end
                end
            end
        end else if (moving) begin
            for (int a = 0; a < tasp_pkg::AXES; a++) begin
                sum = {1'b0, acc_q[a]} + {2'b00, mag_q[a]};
                if (sum >= {1'b0, ticks_total}) begin
                    sum = sum - {1'b0, ticks_total};
                    r.step[a] = 1'b1;
                end
                acc_q[a] = sum[STEP_BITS-1:0];
            end
            ticks_done = ticks_done + {{(STEP_BITS-1){1'b0}}, 1'b1};
            if (ticks_done >= ticks_total) begin
                moving = 1'b0;
                r.finished = 1'b1;
            end
        end
        for (int a = 0; a < tasp_pkg::AXES; a++) begin
            r.dir[a] = dir_q[a];
            r.pos[a] = pos_q[a];
        end
        r.busy = moving;
        expected_reports.push_back(r);
    endtask

    task automatic check_field(input string name,
                               input logic [tasp_pkg::POS_BITS-1:0] exp_v, got_v);
        if (exp_v !== got_v) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, got_v);
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || beat_taken)) begin
            if (gap_in > 0) begin
                i_in_valid <= 1'b0;
                gap_in--;
            end else if (cmd_queue.size() != 0) begin
                cmd = cmd_queue.pop_front();
                i_req_type <= cmd.kind;
                i_delta_x  <= cmd.dx;
                i_delta_y  <= cmd.dy;
                i_delta_z  <= cmd.dz;
                i_in_valid <= 1'b1;
                if (calm_in > 0) begin
                    calm_in--;
                end else if ($urandom_range(0, 19) == 0) begin
                    calm_in = $urandom_range(20, 60);
                end else begin
                    gap_in = idle_len();
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
            if (calm_out > 0) begin
                calm_out--;
            end else if ($urandom_range(0, 39) == 0) begin
                calm_out = $urandom_range(20, 60);
            end else begin
                stall_left = idle_len();
            end
        end
    end

    always @(posedge i_clk) begin
        beat_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: output beat with no report pending", $time);
                    end
                end else begin
                    want = expected_reports.pop_front();
                    check_field("step_x", want.step[0], o_step_x);
                    check_field("step_y", want.step[1], o_step_y);
                    check_field("step_z", want.step[2], o_step_z);
                    check_field("dir_x", want.dir[0], o_dir_x);
                    check_field("dir_y", want.dir[1], o_dir_y);
                    check_field("dir_z", want.dir[2], o_dir_z);
                    check_field("busy_res", want.busy, o_busy_res);
                    check_field("move_finished", want.finished, o_move_finished);
                    check_field("load_ignored", want.ignored, o_load_ignored);
                    check_field("pos_x", want.pos[0], o_pos_x);
                    check_field("pos_y", want.pos[1], o_pos_y);
                    check_field("pos_z", want.pos[2], o_pos_z);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                advance_interpolator(i_req_type, i_delta_x, i_delta_y, i_delta_z);
                beats_in++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("three_axis_step_pulse_interpolator_top: mismatch");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int counted;
        int left;
        logic [STEP_BITS-1:0] dx, dy, dz;

        // Idle tick, zero moves, a mixed-sign move with a dropped load in
        // the middle, single-step moves and an all-negative move.
        push_tick();
        push_move('0, '0, '0);
        push_tick();
        push_move(STEP_BITS'(7), STEP_BITS'(-4), STEP_BITS'(2));
        repeat (3) push_tick();
        push_noise_move();
        repeat (4) push_tick();
        push_move(STEP_BITS'(1), '0, '0);
        push_tick();
        push_move('1, '1, '1);
        push_tick();
        push_move('0, '0, '0);
        push_move(STEP_BITS'(3), STEP_BITS'(-3), STEP_BITS'(3));
        repeat (3) push_tick();
        push_tick();

        counted = 0;
        while (counted < N_RANDOM) begin
            dx = short_delta();
            dy = short_delta();
            dz = short_delta();
            push_move(dx, dy, dz);
            counted++;
            left = span_of(dx);
            if (span_of(dy) > left) left = span_of(dy);
            if (span_of(dz) > left) left = span_of(dz);
            while (left > 0) begin
                if ($urandom_range(0, 99) < 6) begin
                    push_noise_move();
                end else begin
                    push_tick();
                    left--;
                    counted++;
                end
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) push_tick();
            end
        end

        // The move with the extreme deltas never completes, so it closes the run.
        push_move({1'b1, {(STEP_BITS-1){1'b0}}}, MAG_LIMIT, '1);
        repeat (3) push_tick();
        push_move({1'b1, {(STEP_BITS-1){1'b0}}}, '1, MAG_LIMIT);
        push_tick();
        n_items = cmd_queue.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_in < n_items || expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("three_axis_step_pulse_interpolator_top: match");
        end else begin
            $display("three_axis_step_pulse_interpolator_top: mismatch");
        end
        $finish;
    end

endmodule

// ===== three_axis_step_pulse_interpolator_top.f =====
hw/rtl/tasp_pkg.sv
hw/rtl/tasp_axis.sv
hw/rtl/three_axis_step_pulse_interpolator_top.sv
tb/testbench.sv
